[hw/rtl/tilt_complementary_filter_macros.svh]
// Assertion macros shared by the tilt filter RTL.
// Used by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef TILT_COMPLEMENTARY_FILTER_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_MACROS_SVH

// same-cycle implication, off during reset
`define TCF_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TCF_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[hw/rtl/tcf_pkg.sv]
// Package for the tilt complementary filter: types, constants, arithmetic helpers.
// No dependencies; used by tcf_front, tcf_engine and the top level.
package tcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CW           = 36;   // CORDIC x/y width
    localparam int CNT_W        = 6;
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] ITER_LAST   = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST    = CNT_W'(2);   // three 16-bit multiplier slices
    localparam logic signed [31:0] ANGLE_180 = 32'sd11796480;
    localparam logic [47:0] DIV_HALF  = 48'd500;
    // ceil(2^52 / 125): floor(n / 1000) = (floor(n / 8) * GYRO_RECIP) >> 52, exact for n < 2^48
    localparam logic [47:0] GYRO_RECIP = 48'h20C4_9BA5_E354;

    // config register indexes
    localparam logic [1:0] REG_LOWPASS = 2'd0;
    localparam logic [1:0] REG_BLEND   = 2'd1;
    localparam logic [1:0] REG_SHIFT   = 2'd2;

    typedef struct packed {
        logic [15:0] lowpass_keep;
        logic [15:0] blend_keep;
        logic [4:0]  gyro_shift;
    } t_cfg;

    // one queued sample plus its atan2 classification
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic [15:0]        elapsed_ms;
        logic               pitch_zero;
        logic               roll_zero;
        logic               x_neg;
    } t_item;

    // atan(2^-i) in degrees, Q16.16
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117305;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // clamp to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        logic signed [31:0] r;
        if (v > 53'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -53'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round Q.16 product to nearest (halves up), then clamp
    function automatic logic signed [31:0] round16(input logic signed [52:0] v);
        logic signed [52:0] t;
        logic signed [52:0] s;
        t = v + 53'sd32768;
        s = t >>> 16;
        return sat32(s);
    endfunction

endpackage

[hw/rtl/tilt_complementary_filter.sv]
// Top level of the tilt complementary filter: config registers, front queue, engine, output word.
// Depends on tcf_pkg, tcf_front, tcf_engine and tilt_complementary_filter_macros.svh.
//
//  channel   direction  handshake                   payload
//  in        sink       i_in_valid / o_in_stall     accel x/y/z, rate x/y, elapsed_ms
//  out       source     o_out_valid / i_out_stall   pitch, roll, gyro pitch/roll sums
//  cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// In the engine one sample passes through the 16 CORDIC steps; the
// gyro increment's reciprocal multiply runs in the first three of those steps.
// The front queue holds two words, so input is taken while the engine works.
// Reset (synchronous, active low) clears control, filter state and config defaults.
// A stalled output word holds; the engine waits in its last state until the
// output register can take the next word.
`include "tilt_complementary_filter_macros.svh"

module tilt_complementary_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_accel_z,
    input  logic signed [15:0]   i_rate_x,
    input  logic signed [15:0]   i_rate_y,
    input  logic [15:0]          i_elapsed_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_pitch_out,
    output logic signed [31:0]   o_roll_out,
    output logic signed [31:0]   o_gyro_pitch_sum,
    output logic signed [31:0]   o_gyro_roll_sum,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    tcf_pkg::t_cfg   r_cfg;
    tcf_pkg::t_item  item;
    logic            item_valid;
    logic            item_pop;
    logic            eng_res_valid;
    logic            res_take;
    logic signed [31:0] eng_pitch;
    logic signed [31:0] eng_roll;
    logic signed [31:0] eng_gp;
    logic signed [31:0] eng_gr;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lowpass_keep <= 16'd62259;
            r_cfg.blend_keep   <= 16'd62259;
            r_cfg.gyro_shift   <= 5'd14;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tcf_pkg::REG_LOWPASS: r_cfg.lowpass_keep <= i_cfg_data;
                tcf_pkg::REG_BLEND:   r_cfg.blend_keep   <= i_cfg_data;
                tcf_pkg::REG_SHIFT:   r_cfg.gyro_shift   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    tcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_rate_x     (i_rate_x),
        .i_rate_y     (i_rate_y),
        .i_elapsed_ms (i_elapsed_ms),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    tcf_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_item           (item),
        .i_item_valid     (item_valid),
        .o_item_pop       (item_pop),
        .o_res_valid      (eng_res_valid),
        .i_res_take       (res_take),
        .o_pitch_out      (eng_pitch),
        .o_roll_out       (eng_roll),
        .o_gyro_pitch_sum (eng_gp),
        .o_gyro_roll_sum  (eng_gr)
    );

    // output word register
    assign res_take = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_out_valid <= 1'b0;
        else if (res_take)
            o_out_valid <= eng_res_valid;
    end

    always_ff @(posedge i_clk) begin
        if (res_take && eng_res_valid) begin
            o_pitch_out      <= eng_pitch;
            o_roll_out       <= eng_roll;
            o_gyro_pitch_sum <= eng_gp;
            o_gyro_roll_sum  <= eng_gr;
        end
    end

    // checks
    `TCF_ASSERT_IMP(a_pop_nonempty, item_pop, item_valid, "engine popped an empty queue")
    `TCF_ASSERT_NXT(a_handoff_loads, eng_res_valid && res_take, o_out_valid, "result word lost")
    `TCF_ASSERT_IMP(a_out_from_engine, $rose(o_out_valid), $past(eng_res_valid), "word from nowhere")

endmodule

[hw/rtl/tcf_front.sv]
// Front end: accepts samples, classifies the atan2 operands, holds a two-word queue.
// Depends on tcf_pkg.
module tcf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_accel_z,
    input  logic signed [15:0]   i_rate_x,
    input  logic signed [15:0]   i_rate_y,
    input  logic [15:0]          i_elapsed_ms,
    output tcf_pkg::t_item       o_item,
    output logic                 o_item_valid,
    input  logic                 i_item_pop
);

    tcf_pkg::t_item r_mem [2];
    tcf_pkg::t_item n_word;
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           push;

    assign o_stall      = (r_count == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];

    // classify: both operands zero, negative x
    always_comb begin
        n_word.accel_x    = i_accel_x;
        n_word.accel_y    = i_accel_y;
        n_word.accel_z    = i_accel_z;
        n_word.rate_x     = i_rate_x;
        n_word.rate_y     = i_rate_y;
        n_word.elapsed_ms = i_elapsed_ms;
        n_word.pitch_zero = (i_accel_x == 16'sd0) && (i_accel_z == 16'sd0);
        n_word.roll_zero  = (i_accel_y == 16'sd0) && (i_accel_z == 16'sd0);
        n_word.x_neg      = i_accel_z[15];
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wr_ptr] <= n_word;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push)
                r_wr_ptr <= !r_wr_ptr;
            if (i_item_pop)
                r_rd_ptr <= !r_rd_ptr;
            case ({push, i_item_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/tcf_engine.sv]
// Back end: CORDIC atan2, reciprocal gyro multiply, low-pass and output mixes, filter state.
// Depends on tcf_pkg.
module tcf_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcf_pkg::t_cfg        i_cfg,
    input  tcf_pkg::t_item       i_item,
    input  logic                 i_item_valid,
    output logic                 o_item_pop,
    output logic                 o_res_valid,
    input  logic                 i_res_take,
    output logic signed [31:0]   o_pitch_out,
    output logic signed [31:0]   o_roll_out,
    output logic signed [31:0]   o_gyro_pitch_sum,
    output logic signed [31:0]   o_gyro_roll_sum
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SHIFT = 4'd2;
    localparam logic [3:0] S_ITER  = 4'd3;
    localparam logic [3:0] S_INT   = 4'd4;
    localparam logic [3:0] S_LPMUL = 4'd5;
    localparam logic [3:0] S_LPSUM = 4'd6;
    localparam logic [3:0] S_OMUL  = 4'd7;
    localparam logic [3:0] S_OSUM  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam int CW = tcf_pkg::CW;

    logic [3:0]                    r_state, n_state;
    logic [tcf_pkg::CNT_W-1:0]     r_cnt;
    tcf_pkg::t_item                r_item;

    // lane 0 pitch, lane 1 roll
    logic signed [CW-1:0]  r_x [2];
    logic signed [CW-1:0]  r_y [2];
    logic signed [31:0]    r_z [2];
    logic signed [CW-1:0]  n_x [2];
    logic signed [CW-1:0]  n_y [2];
    logic signed [31:0]    n_z [2];
    logic signed [CW-1:0]  x_init [2];
    logic signed [CW-1:0]  y_init [2];
    logic signed [31:0]    z_init [2];
    logic                  zero_l [2];
    logic [31:0]           prod_init [2];
    logic                  neg_init [2];

    logic [31:0]           r_prod [2];
    logic                  r_neg [2];
    logic [44:0]           r_num [2];
    logic [90:0]           r_acc [2];
    logic [90:0]           n_acc [2];
    logic [47:0]           shifted [2];
    logic [15:0]           recip_part;

    logic signed [31:0]    r_meas [2];
    logic signed [31:0]    r_lp [2];
    logic signed [31:0]    r_int [2];
    logic signed [31:0]    r_out [2];
    logic signed [31:0]    n_int [2];
    logic signed [31:0]    n_mix [2];
    logic signed [51:0]    r_pa [2];
    logic signed [51:0]    r_pb [2];
    logic signed [51:0]    n_pa [2];
    logic signed [51:0]    n_pb [2];

    logic [4:0]            step;
    logic                  cordic_on;

    assign step      = r_cnt[4:0];
    assign cordic_on = (r_cnt < tcf_pkg::CORDIC_LAST);

    // CORDIC start vector, gyro magnitude
    always_comb begin
        logic signed [15:0] y0;
        logic signed [15:0] rate;
        logic signed [16:0] r17;
        logic [16:0]        abs17;
        logic [32:0]        p33;
        for (int l = 0; l < 2; l++) begin
            y0   = (l == 0) ? r_item.accel_x : r_item.accel_y;
            rate = (l == 0) ? r_item.rate_y : r_item.rate_x;
            x_init[l] = {{(CW-32){r_item.accel_z[15]}}, r_item.accel_z, 16'b0};
            y_init[l] = {{(CW-32){y0[15]}}, y0, 16'b0};
            z_init[l] = 32'sd0;
            if (r_item.x_neg) begin
                x_init[l] = -x_init[l];
                y_init[l] = -y_init[l];
                z_init[l] = y0[15] ? -tcf_pkg::ANGLE_180 : tcf_pkg::ANGLE_180;
            end
            zero_l[l]    = (l == 0) ? r_item.pitch_zero : r_item.roll_zero;
            r17          = {rate[15], rate};
            abs17        = rate[15] ? 17'(-r17) : 17'(r17);
            p33          = 33'(abs17) * 33'(r_item.elapsed_ms);
            prod_init[l] = p33[31:0];
            neg_init[l]  = rate[15];
            shifted[l]   = ({r_prod[l], 16'b0} >> i_cfg.gyro_shift) + tcf_pkg::DIV_HALF;
        end
    end

    // one CORDIC rotation and one reciprocal slice (high slice first) per lane
    always_comb begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [31:0]   at;
        logic [60:0]          part;
        case (r_cnt[1:0])
            2'd0:    recip_part = tcf_pkg::GYRO_RECIP[47:32];
            2'd1:    recip_part = tcf_pkg::GYRO_RECIP[31:16];
            default: recip_part = tcf_pkg::GYRO_RECIP[15:0];
        endcase
        for (int l = 0; l < 2; l++) begin
            dx = r_y[l] >>> step;
            dy = r_x[l] >>> step;
            at = $signed({10'b0, tcf_pkg::atan_deg(step)});
            if (!r_y[l][CW-1]) begin
                n_x[l] = r_x[l] + dx;
                n_y[l] = r_y[l] - dy;
                n_z[l] = r_z[l] + at;
            end else begin
                n_x[l] = r_x[l] - dx;
                n_y[l] = r_y[l] + dy;
                n_z[l] = r_z[l] - at;
            end
            part     = 61'(r_num[l]) * 61'(recip_part);
            n_acc[l] = {r_acc[l][74:0], 16'b0} + 91'(part);
        end
    end

    // integral update and the two weighted mixes
    always_comb begin
        logic signed [52:0] q53;
        logic signed [33:0] a34;
        logic signed [33:0] b34;
        logic signed [17:0] k18;
        logic signed [17:0] c18;
        for (int l = 0; l < 2; l++) begin
            q53      = $signed({14'b0, r_acc[l][90:52]});
            if (r_neg[l])
                q53 = -q53;
            n_int[l] = tcf_pkg::sat32(53'(r_int[l]) + q53);
            if (r_state == S_OMUL) begin
                a34 = 34'(r_int[l]) + 34'(r_meas[l]);
                b34 = 34'(r_lp[l]);
                k18 = $signed({2'b0, i_cfg.blend_keep});
            end else begin
                a34 = 34'(r_lp[l]);
                b34 = 34'(r_meas[l]);
                k18 = $signed({2'b0, i_cfg.lowpass_keep});
            end
            c18      = 18'sd65536 - k18;
            n_pa[l]  = a34 * k18;
            n_pb[l]  = b34 * c18;
            n_mix[l] = tcf_pkg::round16(53'(r_pa[l]) + 53'(r_pb[l]));
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_item_valid) n_state = S_LOAD;
            S_LOAD:  n_state = S_SHIFT;
            S_SHIFT: n_state = S_ITER;
            S_ITER:  if (r_cnt == tcf_pkg::ITER_LAST) n_state = S_INT;
            S_INT:   n_state = S_LPMUL;
            S_LPMUL: n_state = S_LPSUM;
            S_LPSUM: n_state = S_OMUL;
            S_OMUL:  n_state = S_OSUM;
            S_OSUM:  n_state = S_DONE;
            S_DONE:  if (i_res_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_item_pop  = (r_state == S_IDLE) && i_item_valid;
    assign o_res_valid = (r_state == S_DONE);

    // control state and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            for (int l = 0; l < 2; l++) begin
                r_lp[l]  <= 32'sd0;
                r_int[l] <= 32'sd0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_ITER)
                r_cnt <= r_cnt + 1'b1;
            else
                r_cnt <= '0;
            for (int l = 0; l < 2; l++) begin
                if (r_state == S_INT)
                    r_int[l] <= n_int[l];
                if (r_state == S_LPSUM)
                    r_lp[l] <= n_mix[l];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_item_pop)
            r_item <= i_item;
        for (int l = 0; l < 2; l++) begin
            unique case (r_state)
                S_LOAD: begin
                    r_x[l]    <= x_init[l];
                    r_y[l]    <= y_init[l];
                    r_z[l]    <= z_init[l];
                    r_prod[l] <= prod_init[l];
                    r_neg[l]  <= neg_init[l];
                end
                S_SHIFT: begin
                    // dividing by 8 here leaves a divide by 125 for the reciprocal
                    r_num[l] <= shifted[l][47:3];
                    r_acc[l] <= '0;
                end
                S_ITER: begin
                    if (r_cnt <= tcf_pkg::MUL_LAST)
                        r_acc[l] <= n_acc[l];
                    if (cordic_on) begin
                        r_x[l] <= n_x[l];
                        r_y[l] <= n_y[l];
                        r_z[l] <= n_z[l];
                    end
                end
                S_INT: begin
                    if (zero_l[l])
                        r_meas[l] <= 32'sd0;
                    else
                        r_meas[l] <= (l == 0) ? -r_z[l] : r_z[l];
                end
                S_LPMUL, S_OMUL: begin
                    r_pa[l] <= n_pa[l];
                    r_pb[l] <= n_pb[l];
                end
                S_OSUM: r_out[l] <= n_mix[l];
                default: ;
            endcase
        end
    end

    assign o_pitch_out      = r_out[0];
    assign o_roll_out       = r_out[1];
    assign o_gyro_pitch_sum = r_int[0];
    assign o_gyro_roll_sum  = r_int[1];

endmodule
